// File: sv/hlg_pkg.sv
package hlg_pkg;

   localparam int MAX_LINES = 64;
   localparam int CNT_W     = $clog2(MAX_LINES + 1);
   localparam int ANG_BITS  = 14;
   localparam int ANG_ONE   = 16384;
   localparam int WIDE_W    = 64;

   typedef enum logic [2:0] {
      CSR_ANCHOR_X    = 3'd0,
      CSR_ANCHOR_Y    = 3'd1,
      CSR_DIR_COS     = 3'd2,
      CSR_DIR_SIN     = 3'd3,
      CSR_LINE_GAP    = 3'd4,
      CSR_EDGE_MARGIN = 3'd5,
      CSR_HATCH_ON    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] box_left;
      logic signed [31:0] box_bottom;
      logic signed [31:0] box_right;
      logic signed [31:0] box_top;
   } req_type;

   typedef struct packed {
      logic signed [31:0] seg_x0;
      logic signed [31:0] seg_y0;
      logic signed [31:0] seg_x1;
      logic signed [31:0] seg_y1;
      logic               seg_valid;
      logic               seg_last;
      logic               count_clipped;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] anchor_x;
      logic signed [31:0] anchor_y;
      logic signed [15:0] dir_cos;
      logic signed [15:0] dir_sin;
      logic [30:0]        line_gap;
      logic [30:0]        edge_margin;
      logic               hatch_on;
   } cfg_type;

   // one box, classified and ready for the line loop
   typedef struct packed {
      logic                     is_empty;
      logic                     clip;
      logic                     horiz;
      logic [CNT_W-1:0]         count;
      logic signed [WIDE_W-1:0] kg0;
      logic [WIDE_W-1:0]        step;
      logic signed [WIDE_W-1:0] base0;
      logic signed [WIDE_W-1:0] base1;
      logic [14:0]              den;
      logic signed [31:0]       off;
      logic signed [31:0]       fixed0;
      logic signed [31:0]       fixed1;
   } job_type;

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      if (v > 65'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -65'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

// File: sv/hlg_div.sv
module hlg_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [hlg_pkg::WIDE_W-1:0] num,
   input  logic [hlg_pkg::WIDE_W-1:0]       den,
   output logic                             done,
   output logic signed [hlg_pkg::WIDE_W-1:0] quo,
   output logic [hlg_pkg::WIDE_W-1:0]       rem
);
   import hlg_pkg::*;

   localparam int IW = $clog2(WIDE_W);

   logic                busy_ff, busy_in;
   logic                fix_ff, fix_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [IW-1:0]       cnt_ff, cnt_in;
   logic [WIDE_W-1:0]   mag_ff, mag_in;
   logic [WIDE_W-1:0]   acc_ff, acc_in;
   logic [WIDE_W-1:0]   rem_ff, rem_in;
   logic signed [WIDE_W-1:0] quo_ff, quo_in;
   logic [WIDE_W-1:0]   rout_ff, rout_in;
   logic [WIDE_W:0]     trial;
   logic                fits;

   // floor division, positive divisor, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      fix_in  = 1'b0;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      rout_in = rout_ff;
      trial   = {rem_ff, mag_ff[WIDE_W-1]};
      fits    = trial >= {1'b0, den};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = num[WIDE_W-1];
         mag_in  = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
         acc_in  = '0;
         rem_in  = '0;
         cnt_in  = '1;
      end else if (busy_ff) begin
         rem_in = fits ? WIDE_W'(trial - {1'b0, den}) : trial[WIDE_W-1:0];
         acc_in = {acc_ff[WIDE_W-2:0], fits};
         mag_in = {mag_ff[WIDE_W-2:0], 1'b0};
         cnt_in = cnt_ff - IW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         done_in = 1'b1;
         if (neg_ff && (rem_ff != '0)) begin
            quo_in  = -$signed(acc_ff) - 64'sd1;
            rout_in = den - rem_ff;
         end else if (neg_ff) begin
            quo_in  = -$signed(acc_ff);
            rout_in = '0;
         end else begin
            quo_in  = $signed(acc_ff);
            rout_in = rem_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      mag_ff  <= mag_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      rout_ff <= rout_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rout_ff;

endmodule

// File: sv/hlg_front.sv
module hlg_front (
   input  logic             clock,
   input  logic             reset,
   input  hlg_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  hlg_pkg::req_type req_data,
   output logic             job_valid,
   input  logic             job_ready,
   output hlg_pkg::job_type job
);
   import hlg_pkg::*;

   typedef enum logic [9:0] {
      F_IDLE  = 10'b00_0000_0001,
      F_PREP  = 10'b00_0000_0010,
      F_MULX  = 10'b00_0000_0100,
      F_MULY  = 10'b00_0000_1000,
      F_SUM   = 10'b00_0001_0000,
      F_DIVS  = 10'b00_0010_0000,
      F_WAITS = 10'b00_0100_0000,
      F_DIVE  = 10'b00_1000_0000,
      F_WAITE = 10'b01_0000_0000,
      F_PUSH  = 10'b10_0000_0000
   } fstate_type;

   fstate_type state_ff, state_in;
   req_type    box_ff, box_in;
   logic signed [33:0] xb_ff, yb_ff, xt_ff, yt_ff, xb_in, yb_in, xt_in, yt_in;
   logic signed [15:0] c_ff, s_ff, c_in, s_in;
   logic               horiz_ff, horiz_in;
   logic signed [50:0] pxb_ff, pxt_ff, pyb_ff, pyt_ff;
   logic signed [50:0] pxb_in, pxt_in, pyb_in, pyt_in;
   logic signed [WIDE_W-1:0] ns_ff, ne_ff, b0_ff, b1_ff, ns_in, ne_in, b0_in, b1_in;
   logic signed [WIDE_W-1:0] nks_ff, nks_in, kg0_ff, kg0_in;
   logic               zsin_ff, zsin_in;
   job_type            job_ff, job_in;
   logic               div_start, div_done;
   logic signed [WIDE_W-1:0] div_num, div_quo;
   logic [WIDE_W-1:0]  div_den, div_rem, gap_wide;
   logic signed [15:0] cc, sc;
   logic [29:0]        csq;
   logic signed [34:0] dlo, dhi;
   logic signed [15:0] mop;
   logic signed [64:0] cnt;
   logic               clip;

   function automatic logic signed [15:0] clampang(input logic signed [15:0] v);
      if (v > 16'sd16384) begin
         return 16'sd16384;
      end else if (v < -16'sd16384) begin
         return -16'sd16384;
      end else begin
         return v;
      end
   endfunction

   assign gap_wide = WIDE_W'({cfg.line_gap, 14'b0});

   hlg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_comb begin
      state_in = state_ff;
      box_in   = box_ff;
      xb_in = xb_ff; yb_in = yb_ff; xt_in = xt_ff; yt_in = yt_ff;
      c_in = c_ff; s_in = s_ff; horiz_in = horiz_ff;
      pxb_in = pxb_ff; pxt_in = pxt_ff; pyb_in = pyb_ff; pyt_in = pyt_ff;
      ns_in = ns_ff; ne_in = ne_ff; b0_in = b0_ff; b1_in = b1_ff;
      nks_in = nks_ff; kg0_in = kg0_ff; zsin_in = zsin_ff;
      job_in = job_ff;
      div_start = 1'b0;
      div_num   = -ns_ff;
      div_den   = gap_wide;
      cc = clampang(cfg.dir_cos);
      sc = clampang(cfg.dir_sin);
      if (cc < 16'sd0) begin
         cc = -cc;
         sc = -sc;
      end
      csq  = 30'(cc) * 30'(cc);
      dlo  = (state_ff == F_MULX) ? 35'(xb_ff) - 35'(cfg.anchor_x)
                                  : 35'(yb_ff) - 35'(cfg.anchor_y);
      dhi  = (state_ff == F_MULX) ? 35'(xt_ff) - 35'(cfg.anchor_x)
                                  : 35'(yt_ff) - 35'(cfg.anchor_y);
      mop  = (state_ff == F_MULX) ? s_ff : c_ff;
      cnt  = 65'(div_quo) + 65'(nks_ff) + 65'sd1;
      clip = cnt > 65'(MAX_LINES);

      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               box_in   = req_data;
               state_in = F_PREP;
            end
         end
         F_PREP: begin
            xb_in = 34'(box_ff.box_left)   - $signed({3'b000, cfg.edge_margin});
            yb_in = 34'(box_ff.box_bottom) - $signed({3'b000, cfg.edge_margin});
            xt_in = 34'(box_ff.box_right)  + $signed({3'b000, cfg.edge_margin});
            yt_in = 34'(box_ff.box_top)    + $signed({3'b000, cfg.edge_margin});
            c_in  = cc;
            s_in  = sc;
            horiz_in = csq >= (30'd1 << (2 * ANG_BITS - 1));
            state_in = F_MULX;
         end
         F_MULX: begin
            pxb_in = 51'(mop) * 51'(dlo);
            pxt_in = 51'(mop) * 51'(dhi);
            state_in = F_MULY;
         end
         F_MULY: begin
            pyb_in = 51'(mop) * 51'(dlo);
            pyt_in = 51'(mop) * 51'(dhi);
            state_in = F_SUM;
         end
         F_SUM: begin
            zsin_in = !horiz_ff && (s_ff == 16'sd0);
            if (horiz_ff) begin
               b0_in = 64'(pxb_ff);
               b1_in = 64'(pxt_ff);
               if (s_ff > 16'sd0) begin
                  ns_in = 64'(pyb_ff) - 64'(pxt_ff);
                  ne_in = 64'(pyt_ff) - 64'(pxb_ff);
               end else begin
                  ns_in = 64'(pyb_ff) - 64'(pxb_ff);
                  ne_in = 64'(pyt_ff) - 64'(pxt_ff);
               end
            end else begin
               b0_in = (s_ff < 16'sd0) ? -64'(pyb_ff) : 64'(pyb_ff);
               b1_in = (s_ff < 16'sd0) ? -64'(pyt_ff) : 64'(pyt_ff);
               if (s_ff > 16'sd0) begin
                  ns_in = 64'(pxb_ff) - 64'(pyt_ff);
                  ne_in = 64'(pxt_ff) - 64'(pyb_ff);
               end else begin
                  ns_in = 64'(pyb_ff) - 64'(pxb_ff);
                  ne_in = 64'(pyt_ff) - 64'(pxt_ff);
               end
            end
            state_in = F_DIVS;
         end
         F_DIVS: begin
            div_start = 1'b1;
            state_in  = F_WAITS;
         end
         F_WAITS: begin
            if (div_done) begin
               nks_in   = div_quo;
               kg0_in   = ns_ff + $signed(div_rem);
               state_in = F_DIVE;
            end
         end
         F_DIVE: begin
            div_start = 1'b1;
            div_num   = ne_ff;
            state_in  = F_WAITE;
         end
         F_WAITE: begin
            div_num = ne_ff;
            if (div_done) begin
               job_in.is_empty = !cfg.hatch_on || (cfg.line_gap == '0) || zsin_ff
                                 || (cnt <= 65'sd0);
               job_in.clip   = clip;
               job_in.horiz  = horiz_ff;
               job_in.count  = clip ? CNT_W'(MAX_LINES) : cnt[CNT_W-1:0];
               job_in.kg0    = kg0_ff;
               job_in.step   = gap_wide;
               job_in.base0  = b0_ff;
               job_in.base1  = b1_ff;
               job_in.den    = horiz_ff ? c_ff[14:0]
                               : ((s_ff < 16'sd0) ? 15'(-s_ff) : s_ff[14:0]);
               job_in.off    = horiz_ff ? cfg.anchor_y : cfg.anchor_x;
               job_in.fixed0 = horiz_ff ? sat32(65'(xb_ff)) : sat32(65'(yb_ff));
               job_in.fixed1 = horiz_ff ? sat32(65'(xt_ff)) : sat32(65'(yt_ff));
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (job_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      box_ff <= box_in;
      xb_ff <= xb_in; yb_ff <= yb_in; xt_ff <= xt_in; yt_ff <= yt_in;
      c_ff <= c_in; s_ff <= s_in; horiz_ff <= horiz_in;
      pxb_ff <= pxb_in; pxt_ff <= pxt_in; pyb_ff <= pyb_in; pyt_ff <= pyt_in;
      ns_ff <= ns_in; ne_ff <= ne_in; b0_ff <= b0_in; b1_ff <= b1_in;
      nks_ff <= nks_in; kg0_ff <= kg0_in; zsin_ff <= zsin_in;
      job_ff <= job_in;
   end

   assign req_ready = (state_ff == F_IDLE);
   assign job_valid = (state_ff == F_PUSH);
   assign job       = job_ff;

endmodule

// File: sv/hlg_queue.sv
module hlg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  hlg_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output hlg_pkg::job_type out_job
);
   import hlg_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_job   = slot_ff[rd_ff];

   always_comb begin
      wr_in   = push ? !wr_ff : wr_ff;
      rd_in   = pop ? !rd_ff : rd_ff;
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= in_job;
      end
   end

endmodule

// File: sv/hlg_back.sv
module hlg_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  hlg_pkg::job_type job,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hlg_pkg::rsp_type rsp_data
);
   import hlg_pkg::*;

   typedef enum logic [5:0] {
      B_IDLE  = 6'b00_0001,
      B_DIV0  = 6'b00_0010,
      B_WAIT0 = 6'b00_0100,
      B_DIV1  = 6'b00_1000,
      B_WAIT1 = 6'b01_0000,
      B_SEND  = 6'b10_0000
   } bstate_type;

   bstate_type state_ff, state_in;
   job_type    job_ff, job_in;
   logic signed [WIDE_W-1:0] kg_ff, kg_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic signed [31:0] c0_ff, c0_in;
   rsp_type    rsp_ff, rsp_in;
   logic       div_start, div_done;
   logic signed [WIDE_W-1:0] div_num, div_quo;
   logic [WIDE_W-1:0] div_den, div_rem;
   logic signed [31:0] coord;

   hlg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      kg_in     = kg_ff;
      left_in   = left_ff;
      c0_in     = c0_ff;
      rsp_in    = rsp_ff;
      div_start = (state_ff == B_DIV0) || (state_ff == B_DIV1);
      div_den   = WIDE_W'({job_ff.den, 1'b0});
      // round to nearest, halves upward: floor((2n + d) / 2d)
      if ((state_ff == B_DIV1) || (state_ff == B_WAIT1)) begin
         div_num = ((kg_ff + job_ff.base1) <<< 1) + $signed(WIDE_W'(job_ff.den));
      end else begin
         div_num = ((kg_ff + job_ff.base0) <<< 1) + $signed(WIDE_W'(job_ff.den));
      end
      coord = sat32(65'(job_ff.off) + 65'(div_quo));
      // divider remainder unused here
      if (div_rem == '0) begin
         coord = coord;
      end

      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_in  = job;
               kg_in   = job.kg0;
               left_in = job.count;
               if (job.is_empty) begin
                  rsp_in          = '0;
                  rsp_in.seg_last = 1'b1;
                  left_in         = CNT_W'(1);
                  state_in        = B_SEND;
               end else begin
                  state_in = B_DIV0;
               end
            end
         end
         B_DIV0: begin
            state_in = B_WAIT0;
         end
         B_WAIT0: begin
            if (div_done) begin
               c0_in    = coord;
               state_in = B_DIV1;
            end
         end
         B_DIV1: begin
            state_in = B_WAIT1;
         end
         B_WAIT1: begin
            if (div_done) begin
               if (job_ff.horiz) begin
                  rsp_in.seg_x0 = job_ff.fixed0;
                  rsp_in.seg_y0 = c0_ff;
                  rsp_in.seg_x1 = job_ff.fixed1;
                  rsp_in.seg_y1 = coord;
               end else begin
                  rsp_in.seg_x0 = c0_ff;
                  rsp_in.seg_y0 = job_ff.fixed0;
                  rsp_in.seg_x1 = coord;
                  rsp_in.seg_y1 = job_ff.fixed1;
               end
               rsp_in.seg_valid     = 1'b1;
               rsp_in.seg_last      = (left_ff == CNT_W'(1));
               rsp_in.count_clipped = job_ff.clip;
               state_in = B_SEND;
            end
         end
         B_SEND: begin
            if (rsp_ready) begin
               left_in  = left_ff - CNT_W'(1);
               kg_in    = kg_ff + $signed(job_ff.step);
               state_in = (left_ff == CNT_W'(1)) ? B_IDLE : B_DIV0;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
      end
      job_ff <= job_in;
      kg_ff  <= kg_in;
      c0_ff  <= c0_in;
      rsp_ff <= rsp_in;
   end

   assign job_ready = (state_ff == B_IDLE);
   assign rsp_valid = (state_ff == B_SEND);
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/hatch_line_generator.sv
// Hatch line generator.
// req channel: one box (left, bottom, right, top, Q16.16) per request.
// rsp channel: the hatch segments that cross the widened box, one request
//   each, the final one flagged seg_last; a box with no lines, or hatching
//   off, gives a single result with seg_valid low and all coordinates zero.
//   At most MAX_LINES segments per box; count_clipped marks a box cut short.
// csr channel: register writes (anchor, direction, gap, margin, enable),
//   always ready; write only while no box is in flight.
// Flow: the front widens the box and forms the products, then runs two
//   divisions for the first and last grid index and hands the box on; the
//   back takes it from the queue. For each segment the back-end divider runs
//   two rounding divisions, then the back sends the segment.
// The front and the back each own a one-bit-per-cycle divider; a two-entry
//   queue between them lets the front set up the next boxes while the back
//   is still emitting segments, so the front can take a new box early.
// Reset: synchronous, clears all control state and loads the register
//   defaults (hatching off, direction along x, gap of one unit).
// A stalled receiver holds the current result steady; the back halts and
//   the front keeps going until the queue is full.
module hatch_line_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hlg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hlg_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import hlg_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   job_type q_in_job, q_out_job;

   // register file: decode the index, drop writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ANCHOR_X:    cfg_in.anchor_x    = csr_data;
            CSR_ANCHOR_Y:    cfg_in.anchor_y    = csr_data;
            CSR_DIR_COS:     cfg_in.dir_cos     = csr_data[15:0];
            CSR_DIR_SIN:     cfg_in.dir_sin     = csr_data[15:0];
            CSR_LINE_GAP:    cfg_in.line_gap    = csr_data[30:0];
            CSR_EDGE_MARGIN: cfg_in.edge_margin = csr_data[30:0];
            CSR_HATCH_ON:    cfg_in.hatch_on    = csr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.anchor_x    <= '0;
         cfg_ff.anchor_y    <= '0;
         cfg_ff.dir_cos     <= 16'(ANG_ONE);
         cfg_ff.dir_sin     <= '0;
         cfg_ff.line_gap    <= 31'd65536;
         cfg_ff.edge_margin <= '0;
         cfg_ff.hatch_on    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // front: accept the box, find the index range and classify it
   hlg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (q_in_valid),
      .job_ready (q_in_ready),
      .job       (q_in_job)
   );

   // hold set-up boxes until the back is free
   hlg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_job    (q_in_job),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_job   (q_out_job)
   );

   // back: walk the lines and send one segment per request
   hlg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_out_valid),
      .job_ready (q_out_ready),
      .job       (q_out_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/hlg_checker.sv
module hlg_props (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input hlg_pkg::rsp_type rsp_data
);
   import hlg_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.seg_valid |-> rsp_data.seg_last && !rsp_data.count_clipped)
      else $error("empty result not final or marked clipped");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.seg_valid |->
         (rsp_data.seg_x0 == '0) && (rsp_data.seg_y0 == '0) &&
         (rsp_data.seg_x1 == '0) && (rsp_data.seg_y1 == '0))
      else $error("empty result carries coordinates");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind hatch_line_generator hlg_props u_props (.*);

// File: dv/hlg_checker.sv
`timescale 1ns / 100ps

// Watches the three channels of the hatch line generator, keeps its own copy
// of the registers, predicts the segments of every box and compares.
module hlg_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  hlg_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  hlg_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data,
   output int               mismatches,
   output int               segments_pending
);
   import hlg_pkg::*;

   localparam int UNIT_ANGLE = 16384;
   localparam int LINE_LIMIT = 64;

   logic signed [31:0] grid_x, grid_y;
   logic signed [15:0] cos_reg, sin_reg;
   logic [30:0]        gap_reg, margin_reg;
   logic               enable_reg;

   rsp_type segment_queue[$];

   assign segments_pending = segment_queue.size();

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic longint ceil_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n > 0) q++;
      return q;
   endfunction

   function automatic longint round_quot(longint n, longint d);
      return floor_quot(2 * n + d, 2 * d);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint clamp_angle(longint v);
      if (v > UNIT_ANGLE) return UNIT_ANGLE;
      if (v < -UNIT_ANGLE) return -UNIT_ANGLE;
      return v;
   endfunction

   task automatic push_empty();
      rsp_type r;
      r = '0;
      r.seg_last = 1'b1;
      segment_queue.push_back(r);
   endtask

   task automatic predict_hatch(req_type b);
      longint m, xb, yb, xt, yt, ax, ay, c, s, g;
      longint psx, psy, pex, pey, ns, ne, ks, ke, cnt, n, sg, kg, as, ss;
      bit horiz, clip;
      rsp_type r;
      m  = longint'({33'b0, margin_reg});
      xb = longint'(b.box_left) - m;
      yb = longint'(b.box_bottom) - m;
      xt = longint'(b.box_right) + m;
      yt = longint'(b.box_top) + m;
      ax = longint'(grid_x);
      ay = longint'(grid_y);
      c  = clamp_angle(longint'(cos_reg));
      s  = clamp_angle(longint'(sin_reg));
      g  = longint'({33'b0, gap_reg}) * UNIT_ANGLE;
      sg = 1;
      if (!enable_reg || gap_reg == 0) begin
         push_empty();
         return;
      end
      if (c < 0) begin
         c = -c;
         s = -s;
      end
      horiz = (2 * c * c) >= (64'sd1 << 28);
      if (horiz) begin
         if (s > 0) begin
            psx = xt; psy = yb; pex = xb; pey = yt;
         end else begin
            psx = xb; psy = yb; pex = xt; pey = yt;
         end
      end else begin
         // a zero sine along a steep direction gives no usable line
         if (s == 0) begin
            push_empty();
            return;
         end
         if (s > 0) begin
            psx = xb; psy = yt; pex = xt; pey = yb; sg = -1;
         end else begin
            psx = xb; psy = yb; pex = xt; pey = yt;
         end
      end
      ns  = sg * (-s * (psx - ax) + c * (psy - ay));
      ne  = sg * (-s * (pex - ax) + c * (pey - ay));
      ks  = ceil_quot(ns, g);
      ke  = floor_quot(ne, g);
      cnt = ke - ks + 1;
      if (cnt <= 0) begin
         push_empty();
         return;
      end
      clip = cnt > LINE_LIMIT;
      n    = clip ? LINE_LIMIT : cnt;
      as   = (s < 0) ? -s : s;
      ss   = (s < 0) ? -1 : 1;
      for (longint i = 0; i < n; i++) begin
         kg = (ks + i) * g;
         if (horiz) begin
            r.seg_x0 = clamp32(xb);
            r.seg_y0 = clamp32(ay + round_quot(kg + (xb - ax) * s, c));
            r.seg_x1 = clamp32(xt);
            r.seg_y1 = clamp32(ay + round_quot(kg + (xt - ax) * s, c));
         end else begin
            r.seg_x0 = clamp32(ax + round_quot(kg + ss * (yb - ay) * c, as));
            r.seg_y0 = clamp32(yb);
            r.seg_x1 = clamp32(ax + round_quot(kg + ss * (yt - ay) * c, as));
            r.seg_y1 = clamp32(yt);
         end
         r.seg_valid     = 1'b1;
         r.seg_last      = (i == n - 1);
         r.count_clipped = clip;
         segment_queue.push_back(r);
      end
   endtask

   task automatic report(string what, longint got, longint want);
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic check_segment(rsp_type got);
      rsp_type want;
      if (segment_queue.size() == 0) begin
         $display("%0t result with nothing outstanding", $realtime);
         mismatches++;
         return;
      end
      want = segment_queue.pop_front();
      if (got.seg_x0 !== want.seg_x0) report("seg_x0", got.seg_x0, want.seg_x0);
      if (got.seg_y0 !== want.seg_y0) report("seg_y0", got.seg_y0, want.seg_y0);
      if (got.seg_x1 !== want.seg_x1) report("seg_x1", got.seg_x1, want.seg_x1);
      if (got.seg_y1 !== want.seg_y1) report("seg_y1", got.seg_y1, want.seg_y1);
      if (got.seg_valid !== want.seg_valid)
         report("seg_valid", got.seg_valid, want.seg_valid);
      if (got.seg_last !== want.seg_last)
         report("seg_last", got.seg_last, want.seg_last);
      if (got.count_clipped !== want.count_clipped)
         report("count_clipped", got.count_clipped, want.count_clipped);
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      if (reset) begin
         grid_x     = '0;
         grid_y     = '0;
         cos_reg    = 16'sd16384;
         sin_reg    = '0;
         gap_reg    = 31'd65536;
         margin_reg = '0;
         enable_reg = 1'b0;
      end else begin
         if (req_valid && req_ready) predict_hatch(req_data);
         if (rsp_valid && rsp_ready) check_segment(rsp_data);
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_ANCHOR_X:    grid_x     = csr_data;
               CSR_ANCHOR_Y:    grid_y     = csr_data;
               CSR_DIR_COS:     cos_reg    = csr_data[15:0];
               CSR_DIR_SIN:     sin_reg    = csr_data[15:0];
               CSR_LINE_GAP:    gap_reg    = csr_data[30:0];
               CSR_EDGE_MARGIN: margin_reg = csr_data[30:0];
               CSR_HATCH_ON:    enable_reg = csr_data[0];
               default: ;
            endcase
         end
      end
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import hlg_pkg::*;

   // index past the register list; writes to it must be ignored
   localparam logic [2:0] CSR_SPARE_INDEX = 3'd7;
   localparam int         SETTLE_CYCLES   = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          mismatches;
   int          segments_pending;
   bit          sender_gaps;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hatch_line_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   hlg_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .segments_pending (segments_pending)
   );

   // Hold the write up until it is taken; leave valid high so that a
   // following write does not drop and raise it in one step.
   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Program every register, plus the spare index, then drop valid.
   task automatic program_hatch(logic [31:0] ax, logic [31:0] ay, logic [15:0] cosv,
                                logic [15:0] sinv, logic [30:0] gap, logic [30:0] margin,
                                logic on);
      write_reg(CSR_SPARE_INDEX, $urandom);
      write_reg(CSR_ANCHOR_X, ax);
      write_reg(CSR_ANCHOR_Y, ay);
      write_reg(CSR_DIR_COS, {16'b0, cosv});
      write_reg(CSR_DIR_SIN, {16'b0, sinv});
      write_reg(CSR_LINE_GAP, {1'b0, gap});
      write_reg(CSR_EDGE_MARGIN, {1'b0, margin});
      write_reg(CSR_HATCH_ON, {31'b0, on});
      csr_valid <= 1'b0;
   endtask

   // Offer one box, after a random hold-off when gaps are enabled.
   task automatic send_box(logic [31:0] l, logic [31:0] b, logic [31:0] r, logic [31:0] t);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= '{box_left: l, box_bottom: b, box_right: r, box_top: t};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted segment has been seen,
   // then allow the pipeline to settle before touching registers.
   task automatic drain();
      req_valid <= 1'b0;
      while (segments_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Random box sized against the gap so that most boxes hold a few lines;
   // the odd one is pure noise with wild or inverted edges.
   task automatic random_box(int unsigned gap);
      int          l, b;
      int unsigned w, h;
      if ($urandom_range(0, 29) == 0) begin
         send_box($urandom, $urandom, $urandom, $urandom);
      end else begin
         l = $signed($urandom) >>> 1;
         b = $signed($urandom) >>> 1;
         w = $urandom_range(0, 3 * gap);
         h = $urandom_range(0, 3 * gap);
         send_box(l, b, l + w, b + h);
      end
   endtask

   // Receiver: stall at random before each result, with
   // stretches where it never stalls.
   initial begin
      int stall;
      int calm;
      calm = 0;
      @(negedge clock);
      rsp_ready <= 1'b1;
      forever begin
         if (calm > 0) begin
            calm--;
            stall = 0;
         end else begin
            stall = $urandom_range(0, 10);
            if ($urandom_range(0, 40) == 0) calm = $urandom_range(20, 80);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_ready <= 1'b1;
         end
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      #150_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int unsigned gap, margin;
      logic [15:0] cosv, sinv;
      int          items;
      sender_gaps = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: hatching off after reset, extreme boxes give empty results.
      send_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      drain();

      // Zero gap with hatching on.
      program_hatch(0, 0, 16'sd16384, 0, 0, 0, 1'b1);
      send_box(0, 0, 32'h0003_0000, 32'h0003_0000);
      drain();

      // Plain horizontal grid, then an extreme box that overflows the count.
      program_hatch(0, 0, 16'sd16384, 0, 31'd65536, 0, 1'b1);
      send_box(0, 0, 32'h0003_0000, 32'h0002_8000);
      send_box(32'hFFFF_8000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000);
      send_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      drain();

      // Out-of-range direction with negative cosine: clamp, then flip.
      program_hatch(32'h0001_2345, 32'hFFFE_0000, -16'sd20000, 16'h8000, 31'd40000,
                    31'd1000, 1'b1);
      send_box(0, 0, 32'h0002_0000, 32'h0001_8000);
      send_box(32'hFFFF_0000, 32'h0001_0000, 32'h0000_4000, 32'h0002_0000);
      drain();

      // Both components above range; positive sine along the horizontal branch.
      program_hatch(0, 0, 16'h7FFF, 16'h7FFF, 31'd50000, 0, 1'b1);
      send_box(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000);
      drain();

      // Steep direction with zero sine: no lines.
      program_hatch(0, 0, 0, 0, 31'd65536, 0, 1'b1);
      send_box(0, 0, 32'h0004_0000, 32'h0004_0000);
      drain();

      // Vertical with positive sine, then just past the diagonal with
      // negative sine, maximum gap and margin against extreme boxes.
      program_hatch(32'h0000_8000, 0, 0, 16'sd16384, 31'd65536, 31'd100, 1'b1);
      send_box(0, 0, 32'h0003_0000, 32'h0001_0000);
      send_box(32'hFFFD_0000, 32'h0005_0000, 32'h0000_0000, 32'h0006_0000);
      drain();
      program_hatch(32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'sd11585, -16'sd11585,
                    31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
      send_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_box(0, 0, 0, 0);
      drain();

      // Random phases: a fresh register set each, some with a steady sender.
      for (int phase = 0; phase < 12; phase++) begin
         sender_gaps = ($urandom_range(0, 3) != 0);
         gap    = (phase == 0) ? 1 : $urandom_range(256, 1 << 24);
         margin = $urandom_range(0, gap / 2);
         if ($urandom_range(0, 7) == 0) begin
            cosv = 16'($urandom);
            sinv = 16'($urandom);
         end else begin
            cosv = 16'($urandom_range(0, 32768) - 16384);
            sinv = 16'($urandom_range(0, 32768) - 16384);
         end
         program_hatch($urandom, $urandom, cosv, sinv, 31'(gap), 31'(margin),
                       $urandom_range(0, 9) != 0);
         items = (phase == 0) ? 6 : 33;
         repeat (items) random_box(gap);
         drain();
      end

      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
